>>> hdl/second_chance_page_replacement_top_defines.svh
// Assertion macros shared by the checker of the page replacement block.
`ifndef SECOND_CHANCE_PAGE_REPLACEMENT_TOP_DEFINES_SVH
`define SECOND_CHANCE_PAGE_REPLACEMENT_TOP_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define SCPR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent in the cycle after the antecedent.
`define SCPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/scpr_pkg.sv
// Shared constants and types of the second-chance page replacement block.
package scpr_pkg;

  localparam int MAX_FRAMES_DEF = 16;
  localparam int PAGE_BITS      = 16;
  localparam int FIU_W          = 5;
  localparam int FIDX_W         = 4;
  localparam int TDATA_W        = 40;
  localparam int TUSER_W        = 2;
  localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_req_t;

  typedef struct packed {
    logic                 page_fault;
    logic [PAGE_BITS-1:0] fault_page;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [FIDX_W-1:0]    frame_index;
  } result_t;

endpackage

>>> hdl/scpr_frame_mem.sv
// Frame page memory: one write port and one registered read port.
module scpr_frame_mem #(
  parameter int MAX_FRAMES = scpr_pkg::MAX_FRAMES_DEF,
  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic                           clk,
  input  scpr_pkg::mem_req_t             req,
  input  logic [IDX_W-1:0]               rd_addr,
  input  logic [IDX_W-1:0]               wr_addr,
  input  logic [scpr_pkg::PAGE_BITS-1:0] wr_data,
  output logic [scpr_pkg::PAGE_BITS-1:0] rd_data
);

  logic [scpr_pkg::PAGE_BITS-1:0] mem [MAX_FRAMES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/scpr_ctrl.sv
// Sequencer: lookup scan, fill, clock sweep and eviction over the frame memory.
module scpr_ctrl #(
  parameter int MAX_FRAMES = scpr_pkg::MAX_FRAMES_DEF,
  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [scpr_pkg::FIU_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [scpr_pkg::PAGE_BITS-1:0] in_page,
  output scpr_pkg::mem_req_t             mem_req,
  output logic [IDX_W-1:0]               mem_rd_addr,
  output logic [IDX_W-1:0]               mem_wr_addr,
  output logic [scpr_pkg::PAGE_BITS-1:0] mem_wr_data,
  input  logic [scpr_pkg::PAGE_BITS-1:0] mem_rd_data,
  output scpr_pkg::result_t              res,
  output logic                           res_valid,
  input  logic                           res_ready
);
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_MISS  = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_EVICT = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;

  logic [2:0]                     state, state_next;
  logic [scpr_pkg::FIU_W-1:0]     frames_in_use;
  logic [CNT_W-1:0]               resident_count;
  logic [IDX_W-1:0]               clock_hand;
  logic [MAX_FRAMES-1:0]          ref_bits;
  logic                           cmp_valid;
  logic [scpr_pkg::PAGE_BITS-1:0] page;
  logic [CNT_W-1:0]               issue_idx;
  logic [IDX_W-1:0]               cmp_idx;
  logic [IDX_W-1:0]               sweep_h;
  logic                           res_fault;
  logic                           res_ev_valid;
  logic [scpr_pkg::PAGE_BITS-1:0] res_ev_page;
  logic [IDX_W-1:0]               res_slot;

  logic [CNT_W-1:0] cap;
  logic             issue_ok;
  logic             hit;
  logic             scan_end;
  logic             has_room;
  logic [IDX_W-1:0] sweep_wrap;

  // Effective capacity: zero acts as one, anything above the frame count is clamped.
  always_comb begin
    int unsigned c;
    c = 32'(frames_in_use);
    if (c < 1) c = 1;
    if (c > MAX_FRAMES) c = MAX_FRAMES;
    cap = CNT_W'(c);
  end

  assign issue_ok   = issue_idx < resident_count;
  assign hit        = cmp_valid && (mem_rd_data == page);
  assign scan_end   = cmp_valid && (CNT_W'(cmp_idx) == resident_count - CNT_W'(1));
  assign has_room   = resident_count < cap;
  assign sweep_wrap = (CNT_W'(sweep_h) == cap - CNT_W'(1)) ? '0 : sweep_h + IDX_W'(1);

  assign mem_req.rd_en = ((state == ST_SCAN) && issue_ok) ||
                         ((state == ST_SWEEP) && !ref_bits[sweep_h]);
  assign mem_req.wr_en = ((state == ST_MISS) && has_room) || (state == ST_EVICT);
  assign mem_rd_addr   = (state == ST_SWEEP) ? sweep_h : issue_idx[IDX_W-1:0];
  assign mem_wr_addr   = (state == ST_EVICT) ? sweep_h : resident_count[IDX_W-1:0];
  assign mem_wr_data   = page;

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_RESP);

  assign res.page_fault    = res_fault;
  assign res.fault_page    = page;
  assign res.evicted_valid = res_ev_valid;
  assign res.evicted_page  = res_ev_page;
  assign res.frame_index   = scpr_pkg::FIDX_W'(res_slot);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (resident_count == '0) ? ST_MISS : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_next = ST_RESP;
        end else if (scan_end) begin
          state_next = ST_MISS;
        end
      end
      ST_MISS:  state_next = has_room ? ST_RESP : ST_SWEEP;
      ST_SWEEP: state_next = ref_bits[sweep_h] ? ST_SWEEP : ST_EVICT;
      ST_EVICT: state_next = ST_RESP;
      ST_RESP: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      frames_in_use  <= scpr_pkg::FIU_RESET;
      resident_count <= '0;
      clock_hand     <= '0;
      ref_bits       <= '0;
      cmp_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        // A new capacity empties every frame.
        frames_in_use  <= cfg_data;
        resident_count <= '0;
        clock_hand     <= '0;
        ref_bits       <= '0;
      end else begin
        unique case (state)
          ST_IDLE: cmp_valid <= 1'b0;
          ST_SCAN: begin
            cmp_valid <= issue_ok;
            if (hit) begin
              ref_bits[cmp_idx] <= 1'b1;
            end
          end
          ST_MISS: begin
            if (has_room) begin
              ref_bits[resident_count[IDX_W-1:0]] <= 1'b0;
              resident_count <= resident_count + CNT_W'(1);
            end
          end
          ST_SWEEP: begin
            // A set bit is cleared and the frame gets a second chance.
            if (ref_bits[sweep_h]) begin
              ref_bits[sweep_h] <= 1'b0;
            end
          end
          ST_EVICT: clock_hand <= sweep_wrap;
          ST_RESP:  cmp_valid <= 1'b0;
          default:  cmp_valid <= 1'b0;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        page      <= in_page;
        issue_idx <= '0;
      end
      ST_SCAN: begin
        if (issue_ok) begin
          issue_idx <= issue_idx + CNT_W'(1);
        end
        cmp_idx <= mem_rd_addr;
        if (hit) begin
          res_fault    <= 1'b0;
          res_ev_valid <= 1'b0;
          res_ev_page  <= '0;
          res_slot     <= cmp_idx;
        end
      end
      ST_MISS: begin
        sweep_h      <= clock_hand;
        res_fault    <= 1'b1;
        res_ev_valid <= 1'b0;
        res_ev_page  <= '0;
        res_slot     <= resident_count[IDX_W-1:0];
      end
      ST_SWEEP: begin
        if (ref_bits[sweep_h]) begin
          sweep_h <= sweep_wrap;
        end
      end
      ST_EVICT: begin
        res_ev_valid <= 1'b1;
        res_ev_page  <= mem_rd_data;
        res_slot     <= sweep_h;
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hdl/scpr_out_reg.sv
// Output register that holds one result while the receiver stalls.
module scpr_out_reg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           res_valid,
  input  scpr_pkg::result_t              res,
  output logic                           res_ready,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [scpr_pkg::TDATA_W-1:0]   m_tdata,
  output logic [scpr_pkg::TUSER_W-1:0]   m_tuser
);
  localparam int PAD_W = scpr_pkg::TDATA_W - 2 * scpr_pkg::PAGE_BITS - scpr_pkg::FIDX_W;

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {{PAD_W{1'b0}}, res.frame_index, res.evicted_page, res.fault_page};
      m_tuser <= {res.evicted_valid, res.page_fault};
    end
  end

endmodule

>>> hdl/second_chance_page_replacement_top.sv
// Second-chance (clock) page replacement block, top level.
// Input stream s_*: one page reference per transaction, s_tdata[15:0] = page_number.
// Output stream m_*: one result per reference. m_tuser = {evicted_valid, page_fault};
// m_tdata = {4'b0, frame_index, evicted_page, fault_page}, highest field first.
// Configuration channel cfg_*: writes frames_in_use (reset 16) and empties all frames.
// The user must write it only while no reference is in flight; the block does not enforce
// this. cfg_ready is always high. One reference is processed at a time. The frame pages
// sit in a memory with one registered read port, so the lookup scan reads one resident
// frame per cycle. A hit ends the scan at the matching frame; a miss scans every
// resident frame first (none when no frame is resident), then fills a free frame or,
// when all are in use, sweeps from the hand, clearing each set reference bit it
// passes, and evicts the first frame whose bit is clear.
// s_tready is high only while the sequencer is idle. A finished result waits in the
// output register, so the next reference is taken while the receiver stalls; the
// sequencer holds its next result until that register drains.
// Reset (rst, synchronous) empties every frame, sets the hand to frame 0 and the
// capacity to 16, and drops m_tvalid. No clearing pass is needed.
module second_chance_page_replacement_top #(
  parameter int MAX_FRAMES = scpr_pkg::MAX_FRAMES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [scpr_pkg::PAGE_BITS-1:0] s_tdata,  // [15:0] page_number
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [scpr_pkg::TDATA_W-1:0] m_tdata,    // fault_page, evicted_page, frame_index
  output logic [scpr_pkg::TUSER_W-1:0] m_tuser,    // page_fault, evicted_valid
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [scpr_pkg::FIU_W-1:0]   cfg_data    // frames_in_use
);
  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  scpr_pkg::mem_req_t             mem_req;
  logic [IDX_W-1:0]               mem_rd_addr;
  logic [IDX_W-1:0]               mem_wr_addr;
  logic [scpr_pkg::PAGE_BITS-1:0] mem_wr_data;
  logic [scpr_pkg::PAGE_BITS-1:0] mem_rd_data;
  scpr_pkg::result_t              res;
  logic                           res_valid;
  logic                           res_ready;

  assign cfg_ready = 1'b1;

  scpr_frame_mem #(.MAX_FRAMES(MAX_FRAMES)) u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_addr (mem_rd_addr),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  scpr_ctrl #(.MAX_FRAMES(MAX_FRAMES)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_page     (s_tdata),
    .mem_req     (mem_req),
    .mem_rd_addr (mem_rd_addr),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_data (mem_rd_data),
    .res         (res),
    .res_valid   (res_valid),
    .res_ready   (res_ready)
  );

  scpr_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

>>> hdl/scpr_checker.sv
// Port-level checker for the page replacement block, bound to its top level.
`include "second_chance_page_replacement_top_defines.svh"

module scpr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [scpr_pkg::TDATA_W-1:0] m_tdata,
  input logic [scpr_pkg::TUSER_W-1:0] m_tuser
);

  // A stalled result must hold still.
  `SCPR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  // An eviction only ever happens on a fault.
  `SCPR_ASSERT_SAME(a_evict_fault, m_tvalid && m_tuser[1], m_tuser[0], "eviction without a fault")

  // Without an eviction the evicted page reads as zero.
  `SCPR_ASSERT_SAME(a_evict_zero, m_tvalid && !m_tuser[1], m_tdata[31:16] == '0, "evicted page not zero")

  // References are taken one at a time.
  `SCPR_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second reference taken while busy")

endmodule

bind second_chance_page_replacement_top scpr_checker u_chk (.*);

>>> dv/second_chance_page_replacement_top_test.sv
// Self-checking testbench for the second-chance page replacement block.
module second_chance_page_replacement_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES    = 48;

  // Keeps its own copy of the frames and predicts the outcome of every reference.
  class page_ref_scoreboard;
    logic [scpr_pkg::PAGE_BITS-1:0] frame_page [scpr_pkg::MAX_FRAMES_DEF];
    bit                             ref_bit [scpr_pkg::MAX_FRAMES_DEF];
    int unsigned                    resident;
    int unsigned                    hand;
    logic [scpr_pkg::FIU_W-1:0]     frames_in_use;
    scpr_pkg::result_t              expected_results [$];
    int                             errors;

    function new();
      errors = 0;
      frames_in_use = scpr_pkg::FIU_RESET;
      empty_frames();
    endfunction

    function void empty_frames();
      for (int i = 0; i < scpr_pkg::MAX_FRAMES_DEF; i++) begin
        frame_page[i] = '0;
        ref_bit[i] = 1'b0;
      end
      resident = 0;
      hand = 0;
    endfunction

    function void write_capacity(logic [scpr_pkg::FIU_W-1:0] value);
      frames_in_use = value;
      empty_frames();
    endfunction

    function int unsigned capacity();
      if (frames_in_use < 1) return 1;
      if (frames_in_use > scpr_pkg::MAX_FRAMES_DEF) return scpr_pkg::MAX_FRAMES_DEF;
      return 32'(frames_in_use);
    endfunction

    function void note_ref(logic [scpr_pkg::PAGE_BITS-1:0] page);
      scpr_pkg::result_t r;
      int unsigned       c;
      int unsigned       slot;
      int unsigned       h;
      int unsigned       n;
      bit                hit;
      r = '0;
      c = capacity();
      hit = 1'b0;
      slot = 0;
      for (int i = 0; i < resident; i++) begin
        if (frame_page[i] == page) begin
          hit = 1'b1;
          slot = i;
          ref_bit[i] = 1'b1;
          break;
        end
      end
      if (!hit) begin
        if (resident < c) begin
          slot = resident;
          resident++;
        end else begin
          // Frames with their bit set lose it and are passed over.
          h = hand % c;
          for (n = 0; n < c && ref_bit[h]; n++) begin
            ref_bit[h] = 1'b0;
            h = (h + 1) % c;
          end
          slot = h;
          r.evicted_valid = 1'b1;
          r.evicted_page = frame_page[h];
          hand = (h + 1) % c;
        end
        frame_page[slot] = page;
        ref_bit[slot] = 1'b0;
      end
      r.page_fault = !hit;
      r.fault_page = page;
      r.frame_index = slot[scpr_pkg::FIDX_W-1:0];
      expected_results.push_back(r);
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(input logic [scpr_pkg::TDATA_W-1:0] tdata,
                      input logic [scpr_pkg::TUSER_W-1:0] tuser);
      scpr_pkg::result_t want;
      scpr_pkg::result_t got;
      got.page_fault    = tuser[0];
      got.evicted_valid = tuser[1];
      got.fault_page    = tdata[15:0];
      got.evicted_page  = tdata[31:16];
      got.frame_index   = tdata[35:32];
      if (expected_results.size() == 0) begin
        report($sformatf("result with no reference outstanding, page %h", got.fault_page));
        return;
      end
      want = expected_results.pop_front();
      if (got.page_fault !== want.page_fault)
        report($sformatf("page_fault %b, wanted %b (page %h)",
                         got.page_fault, want.page_fault, want.fault_page));
      if (got.fault_page !== want.fault_page)
        report($sformatf("fault_page %h, wanted %h", got.fault_page, want.fault_page));
      if (got.evicted_valid !== want.evicted_valid)
        report($sformatf("evicted_valid %b, wanted %b (page %h)",
                         got.evicted_valid, want.evicted_valid, want.fault_page));
      if (got.evicted_page !== want.evicted_page)
        report($sformatf("evicted_page %h, wanted %h (page %h)",
                         got.evicted_page, want.evicted_page, want.fault_page));
      if (got.frame_index !== want.frame_index)
        report($sformatf("frame_index %0d, wanted %0d (page %h)",
                         got.frame_index, want.frame_index, want.fault_page));
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [scpr_pkg::PAGE_BITS-1:0] s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [scpr_pkg::TDATA_W-1:0]   m_tdata;
  logic [scpr_pkg::TUSER_W-1:0]   m_tuser;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [scpr_pkg::FIU_W-1:0]     cfg_data = '0;

  page_ref_scoreboard sb;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit long_hold  = 1'b0;

  second_chance_page_replacement_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  task automatic send_ref(input logic [scpr_pkg::PAGE_BITS-1:0] page);
    @(negedge clk);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= page;
    do @(posedge clk); while (!s_tready);
    sb.note_ref(page);
  endtask

  // Stops offering references and waits for every outstanding result.
  task automatic drain_refs();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_frames_in_use(input logic [scpr_pkg::FIU_W-1:0] value);
    drain_refs();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_capacity(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [scpr_pkg::FIU_W-1:0]     phase_cap [12];
    logic [scpr_pkg::PAGE_BITS-1:0] pool [$];
    int                             pool_size;
    int                             items;
    logic [scpr_pkg::PAGE_BITS-1:0] page;

    sb = new();
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed: default capacity, page extremes and hits.
    send_ref(16'h0000);
    send_ref(16'hFFFF);
    send_ref(16'h0000);
    send_ref(16'hA5A5);
    send_ref(16'hFFFF);

    // Zero capacity acts as one frame; a set bit is cleared and the frame still goes.
    write_frames_in_use(5'd0);
    send_ref(16'h1234);
    send_ref(16'h1234);
    send_ref(16'h5678);
    send_ref(16'h9ABC);

    // Three frames, all bits set before a miss, then a hit on a swept frame.
    write_frames_in_use(5'd3);
    send_ref(16'h0001);
    send_ref(16'h0002);
    send_ref(16'h0003);
    send_ref(16'h0001);
    send_ref(16'h0002);
    send_ref(16'h0003);
    send_ref(16'h0004);
    send_ref(16'h0002);
    send_ref(16'h0005);

    // Capacity above the frame count is clamped.
    write_frames_in_use(5'd17);
    send_ref(16'h8000);
    send_ref(16'h7FFF);
    send_ref(16'h8000);

    phase_cap = '{5'd16, 5'd1, 5'd31, 5'd2, 5'd8, 5'd0, 5'd5, 5'd20,
                  5'd12, 5'd3, 5'd16, 5'd7};
    phase_cap[9] = scpr_pkg::FIU_W'($urandom_range(0, 31));

    for (int ph = 0; ph < 12; ph++) begin
      write_frames_in_use(phase_cap[ph]);
      if (ph >= 10) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      if (ph == 2) long_hold = 1'b1;
      // A pool up to three pages larger than the capacity gives a mix of hits and evictions.
      pool.delete();
      pool_size = sb.capacity() + $urandom_range(0, 3);
      for (int k = 0; k < pool_size; k++) pool.push_back(scpr_pkg::PAGE_BITS'($urandom));
      items = 67;
      for (int k = 0; k < items; k++) begin
        if ($urandom_range(0, 99) < 85) page = pool[$urandom_range(0, pool_size - 1)];
        else page = scpr_pkg::PAGE_BITS'($urandom);
        send_ref(page);
        if (ph == 4 && k == items / 2) drain_refs();
      end
    end

    drain_refs();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> second_chance_page_replacement_top.f
+incdir+hdl
hdl/scpr_pkg.sv
hdl/scpr_frame_mem.sv
hdl/scpr_ctrl.sv
hdl/scpr_out_reg.sv
hdl/second_chance_page_replacement_top.sv
hdl/scpr_checker.sv
dv/second_chance_page_replacement_top_test.sv
